/* hdl/cmdsig_pkg.sv */
// Shared constants and types for the command line signature matcher.
`default_nettype none

package cmdsig_pkg;

    localparam int unsigned WIN       = 19;
    localparam int unsigned IND_COUNT = 8;
    localparam int unsigned IDX_W     = $clog2(IND_COUNT);

    typedef logic [7:0] byte_t;
    typedef logic [IND_COUNT-1:0] ind_vec_t;

    // Indicator strings, right-aligned: the last character sits in the lowest byte.
    localparam logic [WIN*8-1:0] IND_PAT [IND_COUNT] = '{
        (WIN*8)'("-encodedcommand"),
        (WIN*8)'("frombase64string"),
        (WIN*8)'("downloadstring"),
        (WIN*8)'("invoke-expression"),
        (WIN*8)'(" iex "),
        (WIN*8)'("-nop"),
        (WIN*8)'("-w hidden"),
        (WIN*8)'("-windowstyle hidden")
    };

    localparam int unsigned IND_LEN [IND_COUNT] = '{15, 16, 14, 17, 5, 4, 9, 19};

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic  valid;
        logic  has_char;
        byte_t char_byte;
        logic  last;
        logic  clear;
    } name_ctl_t;

endpackage

`default_nettype wire

/* hdl/cmdsig_cell.sv */
// One window cell: holds a command line byte and compares its incoming byte.
`default_nettype none

module cmdsig_cell
    import cmdsig_pkg::*;
#(
    parameter int unsigned POS = 0
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  cell_ctl_t  ctl,
    input  byte_t      data_in,
    output byte_t      data_out,
    output ind_vec_t   hit
);

    localparam int unsigned OFFSET = WIN - 1 - POS;

    byte_t data_reg;
    byte_t data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.clear) begin
            data_next = '0;
        end else if (ctl.shift) begin
            data_next = data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        for (int i = 0; i < IND_COUNT; i++) begin
            if (OFFSET < IND_LEN[i]) begin
                hit[i] = (data_in == IND_PAT[i][OFFSET*8 +: 8]);
            end else begin
                hit[i] = 1'b1;
            end
        end
    end

    assign data_out = data_reg;

endmodule

`default_nettype wire

/* hdl/cmdsig_name.sv */
// Process name checker against the two accepted executable names.
`default_nettype none

module cmdsig_name
    import cmdsig_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  name_ctl_t  ctl,
    output logic       name_ok
);

    localparam logic [14*8-1:0] CAND0 = "powershell.exe";
    localparam logic [8*8-1:0]  CAND1 = "pwsh.exe";
    localparam logic [3:0]      LEN0  = 4'd14;
    localparam logic [3:0]      LEN1  = 4'd8;
    localparam logic [3:0]      POS_MAX = 4'd15;

    logic [3:0] pos_reg, pos_next, pos_upd;
    logic [1:0] mismatch_reg, mismatch_next, mismatch_upd;
    logic       ok_reg, ok_next;
    byte_t      cand0_char, cand1_char;

    always_comb begin
        cand0_char = '0;
        cand1_char = '0;
        for (int p = 0; p < 14; p++) begin
            if (pos_reg == 4'(p)) begin
                cand0_char = CAND0[(13-p)*8 +: 8];
            end
        end
        for (int p = 0; p < 8; p++) begin
            if (pos_reg == 4'(p)) begin
                cand1_char = CAND1[(7-p)*8 +: 8];
            end
        end
    end

    always_comb begin
        pos_upd      = pos_reg;
        mismatch_upd = mismatch_reg;
        if (ctl.has_char) begin
            if (pos_reg >= LEN0 || cand0_char != ctl.char_byte) begin
                mismatch_upd[0] = 1'b1;
            end
            if (pos_reg >= LEN1 || cand1_char != ctl.char_byte) begin
                mismatch_upd[1] = 1'b1;
            end
            if (pos_reg != POS_MAX) begin
                pos_upd = pos_reg + 4'd1;
            end
        end

        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        ok_next       = ok_reg;
        if (ctl.clear) begin
            pos_next      = '0;
            mismatch_next = '0;
            ok_next       = 1'b0;
        end else if (ctl.valid) begin
            pos_next      = pos_upd;
            mismatch_next = mismatch_upd;
            if (ctl.last) begin
                ok_next = (!mismatch_upd[0] && pos_upd == LEN0) ||
                          (!mismatch_upd[1] && pos_upd == LEN1);
                pos_next      = '0;
                mismatch_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            mismatch_reg <= '0;
            ok_reg       <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            ok_reg       <= ok_next;
        end
    end

    assign name_ok = ok_reg;

endmodule

`default_nettype wire

/* hdl/command_line_signature_matcher.sv */
// Top level of the command line signature matcher.
`default_nettype none

// Channel | Dir | tdata (low bit up)                     | tuser    | tlast
// s_      | in  | has_char[0], char_byte[8:1], pad[15:9] | segment  | is_last
// m_      | out | alert[0], indicator_index[3:1], pad    | -        | -
//
// One word is taken every cycle while s_tready is high; the byte passes through a row of 19 cells.
// The result of a record appears in the output register in the cycle after the
// command line's last word. Reset clears the window, the flags and the name.
// A held result stalls input only when the output register cannot drain.

module command_line_signature_matcher
    import cmdsig_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,  // has_char, char_byte, padding
    input  wire         s_tuser,  // segment
    input  wire         s_tlast,  // is_last
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata   // alert, indicator_index, padding
);

    logic      accept;
    logic      in_has;
    byte_t     in_byte;
    byte_t     folded;
    logic      cmd_word;
    logic      cmd_end;
    cell_ctl_t cell_ctl;
    name_ctl_t name_ctl;
    logic      name_ok;

    byte_t     win_q   [WIN];
    ind_vec_t  cell_hit [WIN];
    ind_vec_t  hit_all;

    ind_vec_t  found_reg, found_next, found_eff;
    logic      out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic      alert;
    logic [IDX_W-1:0] first_idx;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_has   = s_tdata[0];
    assign in_byte  = s_tdata[8:1];
    assign folded   = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? in_byte + 8'h20 : in_byte;
    assign cmd_word = accept && s_tuser;
    assign cmd_end  = cmd_word && s_tlast;

    assign cell_ctl.shift = cmd_word && in_has;
    assign cell_ctl.clear = cmd_end;

    assign name_ctl.valid     = accept && !s_tuser;
    assign name_ctl.has_char  = in_has;
    assign name_ctl.char_byte = folded;
    assign name_ctl.last      = s_tlast;
    assign name_ctl.clear     = cmd_end;

    cmdsig_name u_name (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (name_ctl),
        .name_ok (name_ok)
    );

    genvar g;
    generate
        for (g = 0; g < WIN; g++) begin : g_cell
            byte_t cell_in;
            if (g == WIN - 1) begin : g_head
                assign cell_in = folded;
            end else begin : g_body
                assign cell_in = win_q[g+1];
            end
            cmdsig_cell #(.POS(g)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .data_in  (cell_in),
                .data_out (win_q[g]),
                .hit      (cell_hit[g])
            );
        end
    endgenerate

    always_comb begin
        hit_all = '1;
        for (int k = 0; k < WIN; k++) begin
            hit_all = hit_all & cell_hit[k];
        end
    end

    always_comb begin
        found_eff = found_reg;
        if (cell_ctl.shift) begin
            found_eff = found_reg | hit_all;
        end
        first_idx = '0;
        for (int i = IND_COUNT - 1; i >= 0; i--) begin
            if (found_eff[i]) begin
                first_idx = IDX_W'(i);
            end
        end
        alert = name_ok && (found_eff != '0);

        found_next = cmd_end ? '0 : found_eff;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd_end) begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, (alert ? first_idx : IDX_W'(0)), alert};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
